// ===== design/llnt_pkg.sv =====
package llnt_pkg;

  localparam int TableEntries = 64;
  localparam int TypeCount    = 16;

  localparam logic [23:0] TimeoutReset = 24'd30000;

  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StAdded    = 3'd1;
  localparam logic [2:0] StDropped  = 3'd2;
  localparam logic [2:0] StSelected = 3'd3;
  localparam logic [2:0] StNone     = 3'd4;

  localparam logic OpHeartbeat = 1'b0;
  localparam logic OpSelect    = 1'b1;

  // one stored table row
  typedef struct packed {
    logic [3:0]  stype;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] cpu;
    logic [15:0] mem;
    logic [15:0] conns;
    logic [47:0] last_seen;
    logic [31:0] order;
  } entry_t;

  // per-entry evaluation handed from the compare unit to the sequencer
  typedef struct packed {
    logic        key_hit;
    logic        type_hit;
    logic        stale;
    logic        better;
    logic [26:0] score;
  } eval_t;

endpackage

// ===== design/llnt_eval.sv =====
// Shared compare unit: looks at one entry per cycle against the current item.
module llnt_eval (
  input  llnt_pkg::entry_t entry,
  input  logic [3:0]       stype,
  input  logic [31:0]      ip,
  input  logic [15:0]      port,
  input  logic [47:0]      now_ms,
  input  logic [23:0]      timeout_ms,
  input  logic             best_vld,
  input  logic [26:0]      best_score,
  input  logic [31:0]      best_order,
  output llnt_pkg::eval_t  res
);

  logic [47:0] age;
  logic [26:0] score;

  always_comb begin
    age = (now_ms >= entry.last_seen) ? (now_ms - entry.last_seen) : 48'd0;
    score = (27'(entry.cpu) * 27'd400) + (27'(entry.mem) * 27'd300)
          + (27'(entry.conns) * 27'd768);
    res.type_hit = (entry.stype == stype);
    res.key_hit  = res.type_hit && (entry.ip == ip) && (entry.port == port);
    res.stale    = (age > {24'd0, timeout_ms});
    res.score    = score;
    res.better   = !best_vld || (score < best_score) ||
                   ((score == best_score) && (entry.order < best_order));
  end

endmodule

// ===== design/least_loaded_node_table.sv =====
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | op, now_ms, node_type, ip, port, loads
// out_    | output    | out_valid/out_ready | status, node fields
// cfg_    | input     | cfg_we              | timeout_ms (cfg_wdata)
// Each input transfer runs a read state, a sweep that looks at one entry per cycle
// through the shared compare unit until all TABLE_ENTRIES entries are seen, and a
// result state; the block takes no new item until it is back in idle. A heartbeat
// adds a write state; a type at or beyond TYPE_COUNT skips the sweep and the write.
// Reset (rst_n low, synchronous) clears the valid bits and insert count, loads the timeout.
// in_ready is low from accept until the result transfer; out_ready low holds the result.
module least_loaded_node_table #(
  parameter int TABLE_ENTRIES = llnt_pkg::TableEntries,
  parameter int TYPE_COUNT    = llnt_pkg::TypeCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [47:0] in_now_ms,
  input  logic [3:0]  in_node_type,
  input  logic [31:0] in_server_ip,
  input  logic [15:0] in_server_port,
  input  logic [15:0] in_cpu_usage,
  input  logic [15:0] in_memory_usage,
  input  logic [15:0] in_connection_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_node_ip,
  output logic [15:0] out_node_port,
  output logic [15:0] out_node_cpu_usage,
  output logic [15:0] out_node_memory_usage,
  output logic [15:0] out_node_connections
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_WRITE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  llnt_pkg::entry_t mem_r [TABLE_ENTRIES];
  llnt_pkg::entry_t rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [23:0] timeout_r;
  logic [31:0] ins_cnt_r;

  logic        op_r;
  logic [47:0] now_r;
  logic [3:0]  type_r;
  logic [31:0] ip_r;
  logic [15:0] port_r, cpu_r, mem_in_r, conns_r;
  logic        type_ok_r;

  logic [AW:0]   rd_idx_r;   // next address to read
  logic [AW-1:0] ev_idx_r;   // address of the entry in rd_r
  logic          hit_r, free_r, best_vld_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic [26:0]   best_score_r;
  logic [31:0]   best_order_r;
  llnt_pkg::entry_t best_r;

  logic [2:0] status_r;
  llnt_pkg::eval_t ev;
  logic ev_live;
  logic [AW-1:0] wr_idx;
  llnt_pkg::entry_t wr_row;

  llnt_eval u_eval (
    .entry(rd_r), .stype(type_r), .ip(ip_r), .port(port_r), .now_ms(now_r),
    .timeout_ms(timeout_r), .best_vld(best_vld_r), .best_score(best_score_r),
    .best_order(best_order_r), .res(ev)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign ev_live   = valid_r[ev_idx_r];
  assign wr_idx    = hit_r ? hit_idx_r : free_idx_r;

  always_comb begin
    wr_row = rd_r;
    if (!hit_r) begin
      wr_row.stype = type_r;
      wr_row.ip    = ip_r;
      wr_row.port  = port_r;
      wr_row.order = ins_cnt_r;
    end else begin
      wr_row = best_r;
    end
    wr_row.cpu       = cpu_r;
    wr_row.mem       = mem_in_r;
    wr_row.conns     = conns_r;
    wr_row.last_seen = now_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = type_ok_r ? S_SWEEP : S_OUT;
      S_SWEEP: if (rd_idx_r == (AW+1)'(TABLE_ENTRIES))
                 state_nxt = (op_r == llnt_pkg::OpHeartbeat) ? S_WRITE : S_OUT;
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      timeout_r <= llnt_pkg::TimeoutReset;
      ins_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
      if (state_r == S_SWEEP && ev_live && ev.type_hit && ev.stale &&
          op_r == llnt_pkg::OpSelect)
        valid_r[ev_idx_r] <= 1'b0;
      if (state_r == S_WRITE && (hit_r || free_r)) begin
        valid_r[wr_idx] <= 1'b1;
        if (!hit_r) ins_cnt_r <= ins_cnt_r + 32'd1;
      end
    end
  end

  // table memory: one registered read, one write
  always_ff @(posedge clk) begin
    rd_r <= mem_r[rd_idx_r[AW-1:0]];
    if (state_r == S_WRITE && (hit_r || free_r)) mem_r[wr_idx] <= wr_row;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        op_r      <= in_op;
        now_r     <= in_now_ms;
        type_r    <= in_node_type;
        ip_r      <= in_server_ip;
        port_r    <= in_server_port;
        cpu_r     <= in_cpu_usage;
        mem_in_r  <= in_memory_usage;
        conns_r   <= in_connection_count;
        type_ok_r <= (32'(in_node_type) < TYPE_COUNT);
        rd_idx_r  <= '0;
        hit_r     <= 1'b0;
        free_r    <= 1'b0;
        best_vld_r <= 1'b0;
        best_r    <= '0;
        status_r  <= (in_op == llnt_pkg::OpHeartbeat) ? llnt_pkg::StDropped
                                                      : llnt_pkg::StNone;
      end
      S_READ: begin
        rd_idx_r <= rd_idx_r + 1'b1;
        ev_idx_r <= '0;
      end
      S_SWEEP: begin
        if (rd_idx_r != (AW+1)'(TABLE_ENTRIES)) rd_idx_r <= rd_idx_r + 1'b1;
        ev_idx_r <= ev_idx_r + 1'b1;
        if (op_r == llnt_pkg::OpHeartbeat) begin
          if (ev_live) begin
            if (!hit_r && ev.key_hit) begin
              hit_r <= 1'b1;
              hit_idx_r <= ev_idx_r;
              best_r <= rd_r;
            end
          end else if (!free_r) begin
            free_r <= 1'b1;
            free_idx_r <= ev_idx_r;
          end
        end else if (ev_live && ev.type_hit && !ev.stale && ev.better) begin
          best_vld_r   <= 1'b1;
          best_score_r <= ev.score;
          best_order_r <= rd_r.order;
          best_r       <= rd_r;
          status_r     <= llnt_pkg::StSelected;
        end
        // preset the drop status; the write cycle settles the heartbeat status
        if (rd_idx_r == (AW+1)'(TABLE_ENTRIES) && op_r == llnt_pkg::OpHeartbeat)
          status_r <= llnt_pkg::StDropped;
      end
      S_WRITE: begin
        status_r <= hit_r ? llnt_pkg::StUpdated :
                    free_r ? llnt_pkg::StAdded : llnt_pkg::StDropped;
        best_r <= '0;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  assign out_status            = status_r;
  assign out_node_ip           = best_r.ip;
  assign out_node_port         = best_r.port;
  assign out_node_cpu_usage    = best_r.cpu;
  assign out_node_memory_usage = best_r.mem;
  assign out_node_connections  = best_r.conns;

endmodule

// ===== design/llnt_checker.sv =====
module llnt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [31:0] out_node_ip
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= llnt_pkg::StNone)) else $error("bad status");

  a_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != llnt_pkg::StSelected) |-> (out_node_ip == 32'd0))
    else $error("node field set without selection");

endmodule

bind least_loaded_node_table llnt_checker u_llnt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_node_ip(out_node_ip)
);

// ===== bench/least_loaded_node_table_checker.sv =====
`timescale 1ns / 100ps

module least_loaded_node_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [47:0] in_now_ms,
  input  logic [3:0]  in_node_type,
  input  logic [31:0] in_server_ip,
  input  logic [15:0] in_server_port,
  input  logic [15:0] in_cpu_usage,
  input  logic [15:0] in_memory_usage,
  input  logic [15:0] in_connection_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_node_ip,
  input  logic [15:0] out_node_port,
  input  logic [15:0] out_node_cpu_usage,
  input  logic [15:0] out_node_memory_usage,
  input  logic [15:0] out_node_connections,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] cpu;
    logic [15:0] mem;
    logic [15:0] conns;
  } verdict_t;

  logic             node_live [llnt_pkg::TableEntries];
  llnt_pkg::entry_t node_row  [llnt_pkg::TableEntries];
  logic [31:0]      insert_count;
  logic [23:0]      timeout_ms;
  verdict_t         expected_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [26:0] load_score(input llnt_pkg::entry_t e);
    return 27'(400 * e.cpu) + 27'(300 * e.mem) + 27'(768 * e.conns);
  endfunction

  function automatic verdict_t balance_item();
    verdict_t    v;
    int          hit, free_slot, best;
    logic [47:0] age;
    logic [26:0] s, best_s;
    v = '0;
    hit = -1;
    free_slot = -1;
    best = -1;
    best_s = '0;
    if (in_op == llnt_pkg::OpHeartbeat) begin
      if (int'(in_node_type) >= llnt_pkg::TypeCount) begin
        v.status = llnt_pkg::StDropped;
        return v;
      end
      for (int i = 0; i < llnt_pkg::TableEntries; i++) begin
        if (node_live[i]) begin
          if (hit < 0 && node_row[i].stype == in_node_type &&
              node_row[i].ip == in_server_ip && node_row[i].port == in_server_port)
            hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        node_row[hit].cpu = in_cpu_usage;
        node_row[hit].mem = in_memory_usage;
        node_row[hit].conns = in_connection_count;
        node_row[hit].last_seen = in_now_ms;
        v.status = llnt_pkg::StUpdated;
      end else if (free_slot >= 0) begin
        node_live[free_slot] = 1'b1;
        node_row[free_slot] = '{in_node_type, in_server_ip, in_server_port,
                                in_cpu_usage, in_memory_usage, in_connection_count,
                                in_now_ms, insert_count};
        insert_count++;
        v.status = llnt_pkg::StAdded;
      end else begin
        v.status = llnt_pkg::StDropped;
      end
      return v;
    end
    if (int'(in_node_type) < llnt_pkg::TypeCount) begin
      for (int i = 0; i < llnt_pkg::TableEntries; i++) begin
        if (node_live[i] && node_row[i].stype == in_node_type) begin
          age = (in_now_ms >= node_row[i].last_seen) ? in_now_ms - node_row[i].last_seen : '0;
          if (age > {24'd0, timeout_ms}) begin
            node_live[i] = 1'b0;
          end else begin
            s = load_score(node_row[i]);
            if (best < 0 || s < best_s ||
                (s == best_s && node_row[i].order < node_row[best].order)) begin
              best = i;
              best_s = s;
            end
          end
        end
      end
    end
    if (best < 0) begin
      v.status = llnt_pkg::StNone;
    end else begin
      v = '{llnt_pkg::StSelected, node_row[best].ip, node_row[best].port,
            node_row[best].cpu, node_row[best].mem, node_row[best].conns};
    end
    return v;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    verdict_t w;
    if (!rst_n) begin
      foreach (node_live[i]) node_live[i] = 1'b0;
      insert_count = '0;
      timeout_ms = llnt_pkg::TimeoutReset;
      expected_q.delete();
    end else begin
      if (cfg_we) timeout_ms = cfg_wdata;
      if (in_valid && in_ready) expected_q.insert(expected_q.size(), balance_item());
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result status", 32'(out_status), 32'd0);
        end else begin
          w = expected_q.pop_front();
          if (out_status !== w.status) report_mismatch("status", 32'(out_status), 32'(w.status));
          if (out_node_ip !== w.ip) report_mismatch("node_ip", out_node_ip, w.ip);
          if (out_node_port !== w.port) report_mismatch("node_port", 32'(out_node_port), 32'(w.port));
          if (out_node_cpu_usage !== w.cpu)
            report_mismatch("node_cpu_usage", 32'(out_node_cpu_usage), 32'(w.cpu));
          if (out_node_memory_usage !== w.mem)
            report_mismatch("node_memory_usage", 32'(out_node_memory_usage), 32'(w.mem));
          if (out_node_connections !== w.conns)
            report_mismatch("node_connections", 32'(out_node_connections), 32'(w.conns));
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

// ===== bench/least_loaded_node_table_tb.sv =====
`timescale 1ns / 100ps

module least_loaded_node_table_tb;

  logic        clk, rst_n, cfg_we;
  logic [23:0] cfg_wdata;
  logic        in_valid, in_ready, in_op;
  logic [47:0] in_now_ms;
  logic [3:0]  in_node_type;
  logic [31:0] in_server_ip;
  logic [15:0] in_server_port, in_cpu_usage, in_memory_usage, in_connection_count;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_node_ip;
  logic [15:0] out_node_port, out_node_cpu_usage, out_node_memory_usage;
  logic [15:0] out_node_connections;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_idle_pct;
  logic [47:0] clock_ms;
  logic [31:0] ip_pool [8];
  logic [15:0] port_pool [8];

  least_loaded_node_table DUT (.*);
  least_loaded_node_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL least_loaded_node_table");
    $finish;
  end

  // receiver stalls at random
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // valid stays high after a transfer until the next item or an idle cycle drops it
  task automatic send_item(input logic op, input logic [47:0] now, input logic [3:0] stype,
                           input logic [31:0] ip, input logic [15:0] port,
                           input logic [15:0] cpu, input logic [15:0] mem,
                           input logic [15:0] conns);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_now_ms <= now;
    in_node_type <= stype;
    in_server_ip <= ip;
    in_server_port <= port;
    in_cpu_usage <= cpu;
    in_memory_usage <= mem;
    in_connection_count <= conns;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic set_timeout(input logic [23:0] value);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a small pool of nodes so updates, ageing and ties happen
  task automatic random_item();
    logic [3:0] stype;
    int         k;
    stype = 4'($urandom_range(3));
    if ($urandom_range(9) == 0) stype = 4'($urandom);
    k = $urandom_range(7);
    clock_ms += $urandom_range(2) == 0 ? 48'($urandom_range(3000)) : 48'($urandom_range(40));
    if ($urandom_range(19) == 0) clock_ms = 48'({$urandom, $urandom});
    if ($urandom_range(2) == 0)
      send_item(llnt_pkg::OpSelect, clock_ms - 48'($urandom_range(5)), stype, $urandom,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else if ($urandom_range(9) == 0)
      send_item(llnt_pkg::OpHeartbeat, clock_ms, stype, $urandom, 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_item(llnt_pkg::OpHeartbeat, clock_ms, stype, ip_pool[k], port_pool[k],
                $urandom_range(3) == 0 ? 16'h0100 : 16'($urandom),
                $urandom_range(3) == 0 ? 16'h0100 : 16'($urandom),
                $urandom_range(3) == 0 ? 16'd5 : 16'($urandom_range(300)));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = llnt_pkg::OpHeartbeat;
    in_now_ms = '0;
    in_node_type = '0;
    in_server_ip = '0;
    in_server_port = '0;
    in_cpu_usage = '0;
    in_memory_usage = '0;
    in_connection_count = '0;
    out_ready = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    clock_ms = 48'd1000;
    foreach (ip_pool[i]) begin
      ip_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // empty select, extremes, equal scores, backwards time
    send_item(llnt_pkg::OpSelect, 48'd0, 4'd0, '0, '0, '0, '0, '0);
    send_item(llnt_pkg::OpHeartbeat, 48'd100, 4'd0, '1, '1, '1, '1, '1);
    send_item(llnt_pkg::OpHeartbeat, 48'd100, 4'd0, '0, '0, 16'h0100, 16'h0100, 16'd5);
    send_item(llnt_pkg::OpHeartbeat, 48'd100, 4'd0, 32'd7, 16'd7, 16'h0100, 16'h0100, 16'd5);
    send_item(llnt_pkg::OpSelect, 48'd50, 4'd0, '0, '0, '0, '0, '0);
    send_item(llnt_pkg::OpHeartbeat, 48'd200, 4'd0, '0, '0, 16'h0200, 16'h0100, 16'd5);
    send_item(llnt_pkg::OpSelect, 48'd200, 4'd0, '0, '0, '0, '0, '0);
    send_item(llnt_pkg::OpHeartbeat, '1, 4'd15, 32'hA5A5_5A5A, 16'h5A5A, '0, '0, '0);
    send_item(llnt_pkg::OpSelect, '1, 4'd15, '0, '0, '0, '0, '0);
    send_item(llnt_pkg::OpSelect, 48'd30300, 4'd0, '0, '0, '0, '0, '0);
    // fill the table past capacity
    for (int i = 0; i < 66; i++)
      send_item(llnt_pkg::OpHeartbeat, 48'd40000, 4'd3, 32'(i), 16'(i), 16'(i), '0, '0);
    send_item(llnt_pkg::OpSelect, 48'd40000, 4'd3, '0, '0, '0, '0, '0);

    set_timeout(24'd0);
    send_item(llnt_pkg::OpSelect, 48'd40001, 4'd3, '0, '0, '0, '0, '0);
    send_item(llnt_pkg::OpSelect, 48'd40001, 4'd15, '0, '0, '0, '0, '0);
    clock_ms = 48'd50000;
    set_timeout(24'hFF_FFFF);

    for (int i = 0; i < 1900; i++) begin
      if (i == 600) begin
        send_idle_pct = 68;
        recv_idle_pct = 19;
        set_timeout(24'd1);
      end
      if (i == 1000) set_timeout(24'd2000);
      if (i == 1300) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timeout(24'd30000);
      end
      random_item();
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("PASS least_loaded_node_table");
    else
      $display("FAIL least_loaded_node_table");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/llnt_pkg.sv
design/llnt_eval.sv
design/least_loaded_node_table.sv
design/llnt_checker.sv
bench/least_loaded_node_table_checker.sv
bench/least_loaded_node_table_tb.sv
